@@ rtl/core/efcb_pkg.sv @@
// Shared types, constants and a lookup function for the fly camera basis unit.
`timescale 1ns / 1ps
package efcb_pkg;

	// Iteration limits of the rotation CORDIC.
	localparam int TRIG_ITERATIONS_DEF = 16;
	localparam int ATAN_DEPTH = 24;

	// Width of Q2.30 working vectors and of the shared multiplier operands.
	localparam int VW = 34;
	localparam int MW = 35;

	// Item selector codes.
	localparam logic [2:0] FUNC_ORIENT   = 3'd0;
	localparam logic [2:0] FUNC_FORWARD  = 3'd1;
	localparam logic [2:0] FUNC_BACKWARD = 3'd2;
	localparam logic [2:0] FUNC_LEFT     = 3'd3;
	localparam logic [2:0] FUNC_RIGHT    = 3'd4;
	localparam logic [2:0] FUNC_INIT     = 3'd5;

	// Angle and arithmetic constants.
	localparam logic signed [16:0] DEG_FULL    = 17'sd23040;
	localparam logic signed [16:0] DEG_QUARTER = 17'sd5760;
	localparam logic [34:0] RAD_SCALE = 35'd19190098068;
	localparam logic signed [VW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [VW-1:0] ONE_Q30 = 34'sd1073741824;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic [15:0] SPEED_DEFAULT = 16'd1600;
	localparam logic signed [15:0] INIT_YAW = -16'sd5760;

	typedef enum logic [4:0] {
		T_IDLE, T_YAW, T_YAW_W, T_PITCH_W, T_FX, T_FZ, T_FTAKE, T_NFS, T_NF,
		T_SSTART, T_NS, T_CROSS, T_USTART, T_NU, T_MDIST, T_MSTEP, T_FIN
	} top_state_t;

	typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ITER, C_OUT} cordic_state_t;

	typedef enum logic [2:0] {N_IDLE, N_SQ, N_SQRT, N_DIVI, N_DIVS, N_DONE} norm_state_t;

	typedef logic [2:0][15:0] axis_t;
	typedef logic [2:0][VW-1:0] wvec_t;

	// Arctangent of 2^-i in Q2.30 radians.
	function automatic logic signed [32:0] atan_q30(input logic [4:0] idx);
		logic signed [32:0] v;
		unique case (idx)
			5'd0: v = 33'sd843314856;
			5'd1: v = 33'sd497837829;
			5'd2: v = 33'sd263043836;
			5'd3: v = 33'sd133525158;
			5'd4: v = 33'sd67021686;
			5'd5: v = 33'sd33543515;
			5'd6: v = 33'sd16775850;
			5'd7: v = 33'sd8388437;
			5'd8: v = 33'sd4194282;
			5'd9: v = 33'sd2097149;
			5'd10: v = 33'sd1048575;
			5'd11: v = 33'sd524287;
			5'd12: v = 33'sd262143;
			5'd13: v = 33'sd131071;
			5'd14: v = 33'sd65535;
			5'd15: v = 33'sd32767;
			5'd16: v = 33'sd16383;
			5'd17: v = 33'sd8191;
			5'd18: v = 33'sd4095;
			5'd19: v = 33'sd2047;
			5'd20: v = 33'sd1023;
			5'd21: v = 33'sd511;
			5'd22: v = 33'sd255;
			5'd23: v = 33'sd127;
			default: v = 33'sd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/efcb_cordic.sv @@
// Iterative rotation CORDIC producing cosine and sine of a Q10.6 degree angle.
`timescale 1ns / 1ps
module efcb_cordic #(
	parameter int TRIG_ITERATIONS = efcb_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [15:0]               angle,
	output logic                             done,
	output logic signed [efcb_pkg::VW-1:0]   cos_val,
	output logic signed [efcb_pkg::VW-1:0]   sin_val
);
	import efcb_pkg::*;

	localparam int NIT = (TRIG_ITERATIONS < ATAN_DEPTH) ? TRIG_ITERATIONS : ATAN_DEPTH;
	localparam int IW = $clog2(NIT);

	cordic_state_t state_q, state_nx;
	logic [1:0] quad_q;
	logic [12:0] rem_q;
	logic signed [VW-1:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [IW-1:0] it_q;

	logic signed [16:0] a0, a1, a2, a3;
	logic [1:0] quad_c;
	logic signed [16:0] rem_c;
	logic [47:0] zprod;
	logic signed [VW-1:0] dx, dy;
	logic signed [32:0] atn;

	// Fold the angle into one turn, then split it into quadrant and remainder.
	always_comb begin
		a0 = {angle[15], angle};
		a1 = (a0 < 0) ? a0 + DEG_FULL : a0;
		a2 = (a1 < 0) ? a1 + DEG_FULL : a1;
		a3 = (a2 >= DEG_FULL) ? a2 - DEG_FULL : a2;
		priority if (a3 < DEG_QUARTER) begin
			quad_c = 2'd0;
			rem_c = a3;
		end else if (a3 < 2 * DEG_QUARTER) begin
			quad_c = 2'd1;
			rem_c = 17'(a3 - DEG_QUARTER);
		end else if (a3 < 3 * DEG_QUARTER) begin
			quad_c = 2'd2;
			rem_c = 17'(a3 - 2 * DEG_QUARTER);
		end else begin
			quad_c = 2'd3;
			rem_c = 17'(a3 - 3 * DEG_QUARTER);
		end
	end

	// Remainder to Q2.30 radians, and one micro-rotation per cycle.
	always_comb begin
		zprod = 48'(rem_q) * 48'(RAD_SCALE);
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		atn = atan_q30(5'(it_q));
	end

	// Sequencer next state; a new start is taken right in the done cycle.
	always_comb begin
		state_nx = state_q;
		done = 1'b0;
		unique case (state_q)
			C_IDLE: if (start) state_nx = C_LOAD;
			C_LOAD: state_nx = (rem_q == 13'd0) ? C_OUT : C_ITER;
			C_ITER: if (it_q == IW'(NIT - 1)) state_nx = C_OUT;
			C_OUT: begin
				done = 1'b1;
				state_nx = start ? C_LOAD : C_IDLE;
			end
			default: state_nx = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Working registers of the rotation.
	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE, C_OUT: begin
				quad_q <= quad_c;
				rem_q <= rem_c[12:0];
			end
			C_LOAD: begin
				z_q <= {1'b0, zprod[47:16]};
				x_q <= (rem_q == 13'd0) ? ONE_Q30 : CORDIC_GAIN;
				y_q <= '0;
				it_q <= '0;
			end
			C_ITER: begin
				if (!z_q[32]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atn;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atn;
				end
				it_q <= it_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Quadrant restore.
	always_comb begin
		unique case (quad_q)
			2'd0: begin
				cos_val = x_q;
				sin_val = y_q;
			end
			2'd1: begin
				cos_val = -y_q;
				sin_val = x_q;
			end
			2'd2: begin
				cos_val = -x_q;
				sin_val = -y_q;
			end
			default: begin
				cos_val = y_q;
				sin_val = -x_q;
			end
		endcase
	end

endmodule

@@ rtl/core/efcb_norm.sv @@
// Vector normalizer: squares, bit-pair square root and restoring division.
`timescale 1ns / 1ps
module efcb_norm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  efcb_pkg::wvec_t        vec,
	output logic                   done,
	output efcb_pkg::axis_t        res
);
	import efcb_pkg::*;

	function automatic logic [VW-1:0] mag(input logic [VW-1:0] v);
		return v[VW-1] ? -v : v;
	endfunction

	norm_state_t state_q, state_nx;
	wvec_t v_q;
	logic [1:0] k_q;
	logic [63:0] sum_q, p_q, n_q, root_q;
	logic [4:0] j_q;
	logic [31:0] len_q, rem_q;
	logic [14:0] nlo_q;
	logic [13:0] quo_q;
	logic [3:0] bc_q;
	axis_t res_q;

	logic [VW-1:0] sel_mag;
	logic [2*VW-1:0] sq_full;
	logic [63:0] sq_bit, sq_try, sq_root_nx, sq_n_nx;
	logic [48:0] num;
	logic [32:0] rem2;
	logic ge;
	logic [14:0] q_fin;
	logic [15:0] q_signed;

	// Component select, square and one root step.
	always_comb begin
		unique case (k_q)
			2'd0: sel_mag = mag(v_q[0]);
			2'd1: sel_mag = mag(v_q[1]);
			2'd2: sel_mag = mag(v_q[2]);
			default: sel_mag = '0;
		endcase
		sq_full = sel_mag * sel_mag;
		sq_bit = 64'd1 << {j_q, 1'b0};
		sq_try = root_q + sq_bit;
		if (n_q >= sq_try) begin
			sq_n_nx = n_q - sq_try;
			sq_root_nx = (root_q >> 1) + sq_bit;
		end else begin
			sq_n_nx = n_q;
			sq_root_nx = root_q >> 1;
		end
	end

	// Rounded numerator and one quotient bit per cycle.
	always_comb begin
		num = (49'(sel_mag) << 14) + 49'(len_q[31:1]);
		rem2 = {rem_q, nlo_q[14]};
		ge = rem2 >= {1'b0, len_q};
		q_fin = {quo_q, ge};
		q_signed = v_q[k_q][VW-1] ? -{1'b0, q_fin} : {1'b0, q_fin};
	end

	// Sequencer next state.
	always_comb begin
		state_nx = state_q;
		done = 1'b0;
		unique case (state_q)
			N_IDLE: if (start) state_nx = N_SQ;
			N_SQ: if (k_q == 2'd3) state_nx = N_SQRT;
			N_SQRT: if (j_q == 5'd0) state_nx = (sq_root_nx == 64'd0) ? N_DONE : N_DIVI;
			N_DIVI: state_nx = N_DIVS;
			N_DIVS: if (bc_q == 4'd0) state_nx = (k_q == 2'd2) ? N_DONE : N_DIVI;
			N_DONE: begin
				done = 1'b1;
				state_nx = N_IDLE;
			end
			default: state_nx = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				v_q <= vec;
				k_q <= 2'd0;
				sum_q <= '0;
			end
			N_SQ: begin
				p_q <= sq_full[63:0];
				if (k_q != 2'd0) sum_q <= sum_q + p_q;
				if (k_q == 2'd3) begin
					n_q <= sum_q + p_q;
					root_q <= '0;
					j_q <= 5'd31;
				end
				k_q <= k_q + 2'd1;
			end
			N_SQRT: begin
				n_q <= sq_n_nx;
				root_q <= sq_root_nx;
				j_q <= j_q - 5'd1;
				k_q <= 2'd0;
				if (j_q == 5'd0) begin
					len_q <= sq_root_nx[31:0];
					res_q <= '0;
				end
			end
			N_DIVI: begin
				rem_q <= num[46:15];
				nlo_q <= num[14:0];
				quo_q <= '0;
				bc_q <= 4'd14;
			end
			N_DIVS: begin
				rem_q <= ge ? 32'(rem2 - {1'b0, len_q}) : rem2[31:0];
				nlo_q <= {nlo_q[13:0], 1'b0};
				quo_q <= q_fin[13:0];
				bc_q <= bc_q - 4'd1;
				if (bc_q == 4'd0) begin
					res_q[k_q] <= q_signed;
					k_q <= k_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule

@@ rtl/core/euler_fly_camera_basis_unit.sv @@
// Top level of the fly camera basis unit: sequencer, shared multiplier and state.
`timescale 1ns / 1ps
// Each beat in gives one beat out holding position and the forward, side and
// vertical axes after the item. Orient and init items run two CORDIC passes,
// for yaw and pitch, and three normalizations, each a bit-pair square root
// and three restoring divisions; angles on a quadrant boundary and
// zero-length vectors finish sooner. Move items make four passes through the
// one 35x35 multiplier; an unused selector goes straight to the result.
// The block takes no new beat while an item is in work, but a finished result
// sits in its own output register so the next item may start while it waits.
module euler_fly_camera_basis_unit #(
	parameter int TRIG_ITERATIONS = efcb_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic [15:0]        elapsed,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] fwd_x,
	output logic signed [15:0] fwd_y,
	output logic signed [15:0] fwd_z,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        move_speed
);
	import efcb_pkg::*;

	top_state_t state_q, state_nx;
	logic [2:0] func_q, cnt_q;
	logic signed [15:0] yaw_q, pitch_q;
	logic [15:0] dt_q, speed_q;
	logic [31:0] dist_q;
	logic [2:0][31:0] pos_q, out_pos_q;
	axis_t fwd_q, side_q, up_q, out_fwd_q, out_side_q, out_up_q;
	logic signed [VW-1:0] cy_q, sy_q, cp_q, sp_q;
	wvec_t vec_q;
	logic signed [2*MW-1:0] mul_p_q;
	logic out_valid_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic cor_start, cor_done, norm_start, norm_done;
	logic signed [VW-1:0] cor_cos, cor_sin;
	axis_t norm_res;
	logic accept, out_load;
	logic use_side, negate;
	axis_t move_axis;
	logic [51:0] rnd;
	logic [31:0] step;
	logic [2:0] pidx;

	efcb_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start),
		.angle((state_q == T_YAW) ? yaw_q : pitch_q),
		.done(cor_done), .cos_val(cor_cos), .sin_val(cor_sin)
	);

	efcb_norm u_norm (
		.clk(clk), .arst_n(arst_n), .start(norm_start), .vec(vec_q),
		.done(norm_done), .res(norm_res)
	);

	// Move direction and rounded step from the multiplier result.
	always_comb begin
		use_side = (func_q == FUNC_LEFT) || (func_q == FUNC_RIGHT);
		negate = (func_q == FUNC_BACKWARD) || (func_q == FUNC_LEFT);
		move_axis = use_side ? side_q : fwd_q;
		rnd = mul_p_q[51:0] + (52'd1 << 19);
		step = rnd[51:20];
		pidx = cnt_q - 3'd1;
	end

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			T_FX: begin
				mul_a = MW'(cy_q);
				mul_b = MW'(cp_q);
			end
			T_FZ: begin
				mul_a = MW'(sy_q);
				mul_b = MW'(cp_q);
			end
			T_MDIST: begin
				mul_a = MW'(speed_q);
				mul_b = MW'(dt_q);
			end
			T_MSTEP: begin
				mul_a = (cnt_q < 3'd3) ? MW'($signed(move_axis[cnt_q[1:0]])) : '0;
				mul_b = (cnt_q == 3'd0) ? MW'(mul_p_q[31:0]) : MW'(dist_q);
			end
			T_CROSS: begin
				unique case (cnt_q)
					3'd0: begin
						mul_a = MW'($signed(side_q[1]));
						mul_b = MW'($signed(fwd_q[2]));
					end
					3'd1: begin
						mul_a = MW'($signed(side_q[2]));
						mul_b = MW'($signed(fwd_q[1]));
					end
					3'd2: begin
						mul_a = MW'($signed(side_q[2]));
						mul_b = MW'($signed(fwd_q[0]));
					end
					3'd3: begin
						mul_a = MW'($signed(side_q[0]));
						mul_b = MW'($signed(fwd_q[2]));
					end
					3'd4: begin
						mul_a = MW'($signed(side_q[0]));
						mul_b = MW'($signed(fwd_q[1]));
					end
					3'd5: begin
						mul_a = MW'($signed(side_q[1]));
						mul_b = MW'($signed(fwd_q[0]));
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer next state and handshake outputs.
	always_comb begin
		state_nx = state_q;
		in_stall = (state_q != T_IDLE);
		// A speed write never shares an edge with an item beat.
		cfg_ready = (state_q == T_IDLE) && !in_valid;
		accept = in_valid && (state_q == T_IDLE);
		cor_start = (state_q == T_YAW) || ((state_q == T_YAW_W) && cor_done);
		norm_start = (state_q == T_NFS) || (state_q == T_SSTART) || (state_q == T_USTART);
		out_load = (state_q == T_FIN) && (!out_valid_q || !out_stall);
		unique case (state_q)
			T_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_ORIENT, FUNC_INIT: state_nx = T_YAW;
						FUNC_FORWARD, FUNC_BACKWARD, FUNC_LEFT, FUNC_RIGHT:
							state_nx = T_MDIST;
						default: state_nx = T_FIN;
					endcase
				end
			end
			T_YAW: state_nx = T_YAW_W;
			T_YAW_W: if (cor_done) state_nx = T_PITCH_W;
			T_PITCH_W: if (cor_done) state_nx = T_FX;
			T_FX: state_nx = T_FZ;
			T_FZ: state_nx = T_FTAKE;
			T_FTAKE: state_nx = T_NFS;
			T_NFS: state_nx = T_NF;
			T_NF: if (norm_done) state_nx = T_SSTART;
			T_SSTART: state_nx = T_NS;
			T_NS: if (norm_done) state_nx = T_CROSS;
			T_CROSS: if (cnt_q == 3'd6) state_nx = T_USTART;
			T_USTART: state_nx = T_NU;
			T_NU: if (norm_done) state_nx = T_FIN;
			T_MDIST: state_nx = T_MSTEP;
			T_MSTEP: if (cnt_q == 3'd3) state_nx = T_FIN;
			T_FIN: if (out_load) state_nx = T_IDLE;
			default: state_nx = T_IDLE;
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			out_valid_q <= 1'b0;
			speed_q <= SPEED_DEFAULT;
			pos_q <= '0;
			fwd_q <= {-ONE_Q14, 16'sd0, 16'sd0};
			side_q <= {16'sd0, 16'sd0, ONE_Q14};
			up_q <= {16'sd0, ONE_Q14, 16'sd0};
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept && (func == FUNC_INIT)) begin
				speed_q <= SPEED_DEFAULT;
				pos_q <= {start_z, start_y, start_x};
			end else if (cfg_valid && cfg_ready) begin
				speed_q <= move_speed;
			end
			if ((state_q == T_MSTEP) && (cnt_q != 3'd0)) begin
				pos_q[pidx[1:0]] <= negate ? pos_q[pidx[1:0]] - step
					: pos_q[pidx[1:0]] + step;
			end
			if ((state_q == T_NF) && norm_done) fwd_q <= norm_res;
			if ((state_q == T_NS) && norm_done) side_q <= norm_res;
			if ((state_q == T_NU) && norm_done) up_q <= norm_res;
		end
	end

	// Working registers of the sequence.
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (accept) begin
			func_q <= func;
			dt_q <= elapsed;
			yaw_q <= (func == FUNC_INIT) ? INIT_YAW : yaw_angle;
			pitch_q <= (func == FUNC_INIT) ? 16'sd0 : pitch_angle;
		end
		unique case (state_q)
			T_YAW_W: if (cor_done) begin
				cy_q <= cor_cos;
				sy_q <= cor_sin;
			end
			T_PITCH_W: if (cor_done) begin
				cp_q <= cor_cos;
				sp_q <= cor_sin;
			end
			T_FZ: vec_q[0] <= mul_p_q[VW+29:30];
			T_FTAKE: begin
				vec_q[2] <= mul_p_q[VW+29:30];
				vec_q[1] <= sp_q;
			end
			T_NF: if (norm_done) begin
				vec_q[0] <= -VW'($signed(norm_res[2]));
				vec_q[1] <= '0;
				vec_q[2] <= VW'($signed(norm_res[0]));
			end
			T_NS: cnt_q <= 3'd0;
			T_CROSS: begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q != 3'd0) begin
					if (!pidx[0]) begin
						vec_q[pidx[2:1]] <= mul_p_q[VW-1:0];
					end else begin
						vec_q[pidx[2:1]] <= vec_q[pidx[2:1]] - mul_p_q[VW-1:0];
					end
				end
			end
			T_MDIST: cnt_q <= 3'd0;
			T_MSTEP: begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd0) dist_q <= mul_p_q[31:0];
			end
			default: ;
		endcase
		if (out_load) begin
			out_pos_q <= pos_q;
			out_fwd_q <= fwd_q;
			out_side_q <= side_q;
			out_up_q <= up_q;
		end
	end

	// Result beat.
	assign out_valid = out_valid_q;
	assign pos_x = out_pos_q[0];
	assign pos_y = out_pos_q[1];
	assign pos_z = out_pos_q[2];
	assign fwd_x = out_fwd_q[0];
	assign fwd_y = out_fwd_q[1];
	assign fwd_z = out_fwd_q[2];
	assign right_x = out_side_q[0];
	assign right_y = out_side_q[1];
	assign right_z = out_side_q[2];
	assign up_x = out_up_q[0];
	assign up_y = out_up_q[1];
	assign up_z = out_up_q[2];

endmodule
